[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the delay line RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define VDL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define VDL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[hdl/vdl_pkg.sv]
// ----------------------------------------------------------------------------
// vdl_pkg
// Shared constants, codes and unit interface types of the delay line.
// ----------------------------------------------------------------------------
package vdl_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int DEPTH_DEF        = 1024;

  localparam logic [1:0] OP_STORE_TIME  = 2'd0;
  localparam logic [1:0] OP_STORE_VALUE = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [2:0] ST_NEG_DELAY   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;

  localparam logic [1:0] CFG_MAX_DELAY  = 2'd0;
  localparam logic [1:0] CFG_CHAN_EN    = 2'd1;
  localparam logic [1:0] CFG_START_TIME = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic         start;
    logic [127:0] dividend;
    logic [63:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[hdl/vdl_ram.sv]
// ----------------------------------------------------------------------------
// vdl_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vdl_ram #(
  parameter int DATA_W = 64,
  parameter int WORDS  = 1024,
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/vdl_mul.sv]
// ----------------------------------------------------------------------------
// vdl_mul
// Iterative 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module vdl_mul (
  input  logic              clk,
  input  logic              rst,
  input  vdl_pkg::mul_req_t req,
  output vdl_pkg::mul_rsp_t rsp
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [2:0]   step;
  logic         busy;
  logic         done;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [127:0] pp_wide;

  always_comb begin
    case (step[1:0])
      2'd0:    begin opa = a[31:0];  opb = b[31:0];  end
      2'd1:    begin opa = a[31:0];  opb = b[63:32]; end
      2'd2:    begin opa = a[63:32]; opb = b[31:0];  end
      default: begin opa = a[63:32]; opb = b[63:32]; end
    endcase
    case (pp_sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        acc  <= '0;
        step <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        // product of this step lands in pp, the previous one is summed
        pp <= opa * opb;
        case (step[1:0])
          2'd0:    pp_sh <= 2'd0;
          2'd3:    pp_sh <= 2'd2;
          default: pp_sh <= 2'd1;
        endcase
        if (step != 3'd0) begin
          acc <= acc + pp_wide;
        end
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

[hdl/vdl_div.sv]
// ----------------------------------------------------------------------------
// vdl_div
// Restoring 128/64 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdl_div (
  input  logic              clk,
  input  logic              rst,
  input  vdl_pkg::div_req_t req,
  output vdl_pkg::div_rsp_t rsp
);

  localparam int STEPS = 128;
  localparam int CNT_W = $clog2(STEPS);

  logic [127:0]     dvd;
  logic [63:0]      dsr;
  logic [63:0]      r;
  logic [63:0]      q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [63:0]      rs;
  logic             take;

  always_comb begin
    rs   = {r[62:0], dvd[127]};
    take = r[63] || (rs >= dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        r    <= '0;
        q    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        r   <= take ? (rs - dsr) : rs;
        q   <= {q[62:0], take};
        dvd <= {dvd[126:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = q;

endmodule

[hdl/variable_delay_line_interp.sv]
// ----------------------------------------------------------------------------
// variable_delay_line_interp
// Time-stamped multi-channel delay line with linear interpolation, Q32.32.
// ----------------------------------------------------------------------------
// One transaction at a time: in_stall is high from acceptance until the
// result is loaded into the output register, which then waits for the sink
// while the next transaction is taken. A store-time scans the stored stamps
// (up to the fill count) through the single read port of the time memory.
// A query scans them the same way; when it interpolates rather than ending
// on a stored sample, it also forms two products on the 32x32 partial
// product multiplier and a quotient on the bit-serial divider. Both
// memories start undefined and need no clearing pass; only entries below
// the fill counts are ever read.
module variable_delay_line_interp #(
  parameter int NUM_CHANNELS = vdl_pkg::NUM_CHANNELS_DEF,
  parameter int DEPTH        = vdl_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [2:0]         channel,
  input  logic signed [63:0] sample_value,
  input  logic signed [63:0] time_stamp,
  input  logic signed [63:0] delay_amount,
  // result transaction
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] delayed_value,
  output logic [2:0]         status,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

`include "assert_macros.svh"

  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = AW + 1;
  localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VWORD = NUM_CHANNELS * DEPTH;
  localparam int VAW   = (VWORD > 1) ? $clog2(VWORD) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_T_SCAN_RD, S_T_SCAN_CMP, S_T_TRIM, S_T_FULL, S_T_WRITE,
    S_Q_OLD_RD, S_Q_OLD_CAP, S_Q_LAST_RD, S_Q_LAST_CMP,
    S_Q_SCAN_RD, S_Q_SCAN_CMP, S_Q_V1_RD, S_Q_V1_CAP,
    S_Q_T0_RD, S_Q_T0_CAP, S_Q_V0_RD, S_Q_V0_CAP,
    S_Q_SEL, S_Q_PREP, S_Q_MA_GO, S_Q_MA_WAIT, S_Q_MB_GO, S_Q_MB_WAIT,
    S_Q_ADD, S_Q_ABS, S_Q_DIV_GO, S_Q_DIV_WAIT, S_FINISH
  } state_t;

  state_t state;

  // captured transaction
  logic [1:0]         op_r;
  logic [2:0]         ch_r;
  logic signed [63:0] xv_r;
  logic signed [63:0] now_r;
  logic signed [63:0] dly_r;

  // working registers
  logic signed [63:0] thr;
  logic signed [63:0] ts;
  logic signed [63:0] t0;
  logic signed [63:0] t1;
  logic signed [63:0] v0;
  logic signed [63:0] v1;
  logic [63:0]        dt0;
  logic [63:0]        dt1;
  logic [63:0]        span;
  logic [127:0]       sum;
  logic [127:0]       term;
  logic               neg;
  logic [CNTW-1:0]    idx;
  logic signed [63:0] res_r;
  logic [2:0]         st_r;

  // ring state and registers
  logic [AW-1:0]      oldest_pointer;
  logic [CNTW-1:0]    time_count;
  logic [CNTW-1:0]    channel_count [NUM_CHANNELS];
  logic [62:0]        max_delay;
  logic [7:0]         channel_enable;
  logic signed [63:0] start_time;

  // combinational helpers
  logic [CW-1:0]      ch_idx;
  logic               ch_ok;
  logic [CNTW-1:0]    cc;
  logic [CNTW-1:0]    t_arg;
  logic [CNTW-1:0]    v_arg;
  logic [AW-1:0]      t_slot;
  logic [AW-1:0]      v_slot;
  logic [VAW-1:0]     v_addr;
  logic               drop_en;
  logic [CNTW-1:0]    drop_n;
  logic [CNTW-1:0]    n_cl;
  logic [AW-1:0]      oldest_drop;
  logic [64:0]        thr_diff;
  logic signed [63:0] thr_next;
  logic [63:0]        t_rdata;
  logic [63:0]        v_rdata;
  logic               t_we;
  logic               v_we;
  logic [63:0]        v_mag;

  vdl_pkg::mul_req_t  mul_req;
  vdl_pkg::mul_rsp_t  mul_rsp;
  vdl_pkg::div_req_t  div_req;
  vdl_pkg::div_rsp_t  div_rsp;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CNTW-1:0] off);
    logic [CNTW-1:0] s;
    s = CNTW'(base) + off;
    if (s >= CNTW'(DEPTH)) begin
      s = s - CNTW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    ch_idx = CW'(ch_r);
    ch_ok  = (int'(ch_r) < NUM_CHANNELS) && channel_enable[ch_r];
    cc     = channel_count[ch_idx];

    // ring offsets for the two memory ports
    case (state)
      S_Q_LAST_RD: t_arg = time_count - 1'b1;
      S_T_WRITE:   t_arg = time_count;
      default:     t_arg = idx;
    endcase
    v_arg  = (state == S_DISPATCH) ? cc : idx;
    t_slot = wrap_add(oldest_pointer, t_arg);
    v_slot = wrap_add(oldest_pointer, v_arg);
    v_addr = VAW'(ch_idx * DEPTH) + VAW'(v_slot);

    t_we = (state == S_T_WRITE);
    v_we = (state == S_DISPATCH) && (op_r == vdl_pkg::OP_STORE_VALUE) && ch_ok &&
           (cc < CNTW'(DEPTH));

    // drop from the head: trim keeps one entry below the threshold,
    // a full store gives up its oldest entry
    case (state)
      S_T_TRIM: begin
        drop_en = (idx >= CNTW'(2));
        drop_n  = idx - 1'b1;
      end
      S_T_FULL: begin
        drop_en = (time_count >= CNTW'(DEPTH));
        drop_n  = CNTW'(1);
      end
      default: begin
        drop_en = 1'b0;
        drop_n  = '0;
      end
    endcase
    n_cl        = (drop_n > time_count) ? time_count : drop_n;
    oldest_drop = wrap_add(oldest_pointer, n_cl);

    // trim threshold, saturated at the bottom of the range
    thr_diff = {now_r[63], now_r} - {2'b00, max_delay};
    thr_next = (thr_diff[64] != thr_diff[63]) ? {1'b1, 63'd0} : thr_diff[63:0];

    v_mag = (state == S_Q_MA_GO) ? (v0[63] ? -v0 : v0) : (v1[63] ? -v1 : v1);

    mul_req.start = (state == S_Q_MA_GO) || (state == S_Q_MB_GO);
    mul_req.a     = v_mag;
    mul_req.b     = (state == S_Q_MA_GO) ? dt0 : dt1;

    div_req.start    = (state == S_Q_DIV_GO) && (span != 64'd0);
    div_req.dividend = sum;
    div_req.divisor  = span;
  end

  vdl_ram #(.DATA_W(64), .WORDS(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_slot),
    .wdata (now_r),
    .raddr (t_slot),
    .rdata (t_rdata)
  );

  vdl_ram #(.DATA_W(64), .WORDS(VWORD)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_addr),
    .wdata (xv_r),
    .raddr (v_addr),
    .rdata (v_rdata)
  );

  vdl_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  vdl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      oldest_pointer <= '0;
      time_count     <= '0;
      max_delay      <= '0;
      channel_enable <= '0;
      start_time     <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        channel_count[c] <= '0;
      end
    end else begin
      // release the result once the sink takes it; a finishing transaction
      // reloads the register itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      // register writes, taken only while idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vdl_pkg::CFG_MAX_DELAY:  max_delay <= cfg_data[62:0];
          vdl_pkg::CFG_CHAN_EN: begin
            channel_enable <= cfg_data[7:0];
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (c < 8 && cfg_data[c[2:0]]) begin
                channel_count[c] <= '0;
              end
            end
          end
          vdl_pkg::CFG_START_TIME: start_time <= cfg_data;
          default: ;
        endcase
      end

      // head drop shared by the trim and the full-store case
      if (drop_en) begin
        oldest_pointer <= oldest_drop;
        time_count     <= time_count - n_cl;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          channel_count[c] <= channel_count[c] -
                              ((channel_count[c] < n_cl) ? channel_count[c] : n_cl);
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= opcode;
            ch_r  <= channel;
            xv_r  <= sample_value;
            now_r <= time_stamp;
            dly_r <= delay_amount;
            state <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          res_r <= '0;
          st_r  <= vdl_pkg::ST_OK;
          idx   <= '0;
          state <= S_FINISH;
          case (op_r)
            vdl_pkg::OP_STORE_TIME: begin
              thr   <= thr_next;
              state <= S_T_SCAN_RD;
            end
            vdl_pkg::OP_STORE_VALUE: begin
              if (!ch_ok) begin
                st_r <= vdl_pkg::ST_BAD_CHANNEL;
              end else if (cc >= CNTW'(DEPTH)) begin
                st_r <= vdl_pkg::ST_OVERFLOW;
              end else begin
                channel_count[ch_idx] <= cc + 1'b1;
              end
            end
            vdl_pkg::OP_QUERY: begin
              ts <= now_r - dly_r;
              if (!ch_ok) begin
                st_r <= vdl_pkg::ST_BAD_CHANNEL;
              end else if (dly_r < 0) begin
                st_r <= vdl_pkg::ST_NEG_DELAY;
              end else if (time_count == '0 || now_r <= start_time) begin
                // pass the current value through
                res_r <= xv_r;
              end else if (now_r <= dly_r) begin
                if (cc == '0) begin
                  st_r <= vdl_pkg::ST_NOT_FOUND;
                end else begin
                  state <= S_Q_OLD_RD;
                end
              end else begin
                state <= S_Q_LAST_RD;
              end
            end
            default: ;
          endcase
        end

        // store-time: find the first stamp at or above the threshold
        S_T_SCAN_RD: begin
          state <= (idx >= time_count) ? S_T_TRIM : S_T_SCAN_CMP;
        end
        S_T_SCAN_CMP: begin
          if ($signed(t_rdata) >= thr) begin
            state <= S_T_TRIM;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_T_SCAN_RD;
          end
        end
        S_T_TRIM: state <= S_T_FULL;
        S_T_FULL: begin
          if (drop_en) begin
            st_r <= vdl_pkg::ST_OVERFLOW;
          end
          state <= S_T_WRITE;
        end
        S_T_WRITE: begin
          time_count <= time_count + 1'b1;
          state      <= S_FINISH;
        end

        // query: time at or below the delay gives the oldest sample
        S_Q_OLD_RD:  state <= S_Q_OLD_CAP;
        S_Q_OLD_CAP: begin
          res_r <= v_rdata;
          state <= S_FINISH;
        end

        S_Q_LAST_RD:  state <= S_Q_LAST_CMP;
        S_Q_LAST_CMP: begin
          if (ts > $signed(t_rdata)) begin
            // past the newest stamp: head toward the current sample
            if (cc == '0) begin
              st_r  <= vdl_pkg::ST_NOT_FOUND;
              state <= S_FINISH;
            end else begin
              t0    <= t_rdata;
              t1    <= now_r;
              v1    <= xv_r;
              idx   <= cc - 1'b1;
              state <= S_Q_V0_RD;
            end
          end else begin
            state <= S_Q_SCAN_RD;
          end
        end

        S_Q_SCAN_RD: begin
          if (idx >= time_count) begin
            st_r  <= vdl_pkg::ST_NOT_FOUND;
            state <= S_FINISH;
          end else begin
            state <= S_Q_SCAN_CMP;
          end
        end
        S_Q_SCAN_CMP: begin
          if ($signed(t_rdata) >= ts) begin
            if (idx >= cc) begin
              st_r  <= vdl_pkg::ST_NOT_FOUND;
              state <= S_FINISH;
            end else begin
              t1    <= t_rdata;
              state <= S_Q_V1_RD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_Q_SCAN_RD;
          end
        end

        S_Q_V1_RD:  state <= S_Q_V1_CAP;
        S_Q_V1_CAP: begin
          v1 <= v_rdata;
          if (idx == '0) begin
            res_r <= v_rdata;
            state <= S_FINISH;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_Q_T0_RD;
          end
        end
        S_Q_T0_RD:  state <= S_Q_T0_CAP;
        S_Q_T0_CAP: begin
          t0    <= t_rdata;
          state <= S_Q_V0_RD;
        end
        S_Q_V0_RD:  state <= S_Q_V0_CAP;
        S_Q_V0_CAP: begin
          v0    <= v_rdata;
          state <= S_Q_SEL;
        end

        // exact hits skip the arithmetic
        S_Q_SEL: begin
          dt0 <= t1 - ts;
          if (t0 == ts) begin
            res_r <= v0;
            state <= S_FINISH;
          end else if (t1 == ts) begin
            res_r <= v1;
            state <= S_FINISH;
          end else begin
            state <= S_Q_PREP;
          end
        end
        S_Q_PREP: begin
          dt1   <= ts - t0;
          span  <= t1 - t0;
          state <= S_Q_MA_GO;
        end
        S_Q_MA_GO: state <= S_Q_MA_WAIT;
        S_Q_MA_WAIT: begin
          if (mul_rsp.done) begin
            sum   <= v0[63] ? -mul_rsp.p : mul_rsp.p;
            state <= S_Q_MB_GO;
          end
        end
        S_Q_MB_GO: state <= S_Q_MB_WAIT;
        S_Q_MB_WAIT: begin
          if (mul_rsp.done) begin
            term  <= v1[63] ? -mul_rsp.p : mul_rsp.p;
            state <= S_Q_ADD;
          end
        end
        S_Q_ADD: begin
          sum   <= sum + term;
          state <= S_Q_ABS;
        end
        S_Q_ABS: begin
          neg   <= sum[127];
          sum   <= sum[127] ? -sum : sum;
          state <= S_Q_DIV_GO;
        end
        S_Q_DIV_GO: begin
          if (span == 64'd0) begin
            res_r <= v0;
            state <= S_FINISH;
          end else begin
            state <= S_Q_DIV_WAIT;
          end
        end
        S_Q_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_r <= neg ? -div_rsp.quotient : div_rsp.quotient;
            state <= S_FINISH;
          end
        end

        // hold the result until the output register is free
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            delayed_value <= res_r;
            status        <= st_r;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `VDL_ASSERT_IMPL(a_ring_bound, clk, rst, 1'b1, (time_count <= CNTW'(DEPTH)) && (CNTW'(oldest_pointer) < CNTW'(DEPTH)))
  `VDL_ASSERT_IMPL(a_zero_on_error, clk, rst, out_valid && (status != vdl_pkg::ST_OK), delayed_value == 64'sd0)
  `VDL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `VDL_ASSERT_IMPL(a_mul_done_waited, clk, rst, mul_rsp.done, (state == S_Q_MA_WAIT) || (state == S_Q_MB_WAIT))

endmodule

[dv/tb_variable_delay_line_interp.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_delay_line_interp
// Self-checking bench for the time-stamped delay line: a local model of the
// stamp ring and the per-channel sample rings predicts every result, which the
// monitor compares in order with what the block returns.
// ----------------------------------------------------------------------------
module tb_variable_delay_line_interp;

  localparam int NCH = vdl_pkg::NUM_CHANNELS_DEF;
  localparam int DEP = vdl_pkg::DEPTH_DEF;
  localparam logic signed [63:0] ONE   = 64'sh1_0000_0000;  // 1.0 in Q32.32
  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         ch;
    logic signed [63:0] xv;
    logic signed [63:0] now;
    logic signed [63:0] dly;
  } item_t;

  typedef struct {
    logic signed [63:0] val;
    logic [2:0]         st;
  } answer_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [2:0] channel = '0;
  logic signed [63:0] sample_value = '0;
  logic signed [63:0] time_stamp = '0;
  logic signed [63:0] delay_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] delayed_value;
  logic [2:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  variable_delay_line_interp dut (.*);

  // --------------------------------------------------------------------------
  // Local model of the delay line state
  // --------------------------------------------------------------------------
  logic [63:0] stamp_ring [DEP];
  logic [63:0] sample_ring [NCH][DEP];
  logic [9:0]  head_ptr;
  int unsigned stamp_cnt;
  int unsigned sample_cnt [NCH];
  logic [62:0] max_dly_reg;
  logic [7:0]  chan_en_reg;
  logic signed [63:0] start_reg;

  function automatic logic signed [63:0] stamp_at(int unsigned i);
    return stamp_ring[10'(head_ptr + i)];
  endfunction

  function automatic logic signed [63:0] sample_at(int unsigned c, int unsigned i);
    return sample_ring[c][10'(head_ptr + i)];
  endfunction

  // Advance the ring head; every channel loses the same count, or all it holds if fewer.
  function automatic void drop_entries(int unsigned n);
    if (n > stamp_cnt) n = stamp_cnt;
    head_ptr  = 10'(head_ptr + n);
    stamp_cnt -= n;
    for (int c = 0; c < NCH; c++)
      sample_cnt[c] -= (sample_cnt[c] < n) ? sample_cnt[c] : n;
  endfunction

  // Weighted mean of two neighbours, exact 128-bit products, quotient
  // truncated toward zero and kept to 64 bits.
  function automatic logic signed [63:0] lerp(logic signed [63:0] v0,
      logic signed [63:0] v1, logic signed [63:0] t0, logic signed [63:0] t1,
      logic signed [63:0] ts);
    logic [63:0] dt0, dt1, span, q64;
    logic signed [127:0] pa, pb, sum;
    logic [127:0] mag, quo;
    dt0  = t1 - ts;
    dt1  = ts - t0;
    span = t1 - t0;
    if (span == 0) return v0;
    pa  = $signed({{64{v0[63]}}, v0}) * $signed({64'd0, dt0});
    pb  = $signed({{64{v1[63]}}, v1}) * $signed({64'd0, dt1});
    sum = pa + pb;
    mag = sum[127] ? -sum : sum;
    quo = mag / {64'd0, span};
    q64 = quo[63:0];
    return sum[127] ? -q64 : q64;
  endfunction

  function automatic answer_t lookup(item_t it);
    answer_t a;
    int unsigned cc, idx;
    logic signed [63:0] ts, tl, t0, t1, v0, v1;
    a.val = '0;
    a.st  = vdl_pkg::ST_OK;
    cc = sample_cnt[it.ch];
    if (it.dly < 0) begin
      a.st = vdl_pkg::ST_NEG_DELAY;
      return a;
    end
    if (stamp_cnt == 0 || it.now <= start_reg) begin
      a.val = it.xv;
      return a;
    end
    if (it.now <= it.dly) begin
      if (cc == 0) a.st = vdl_pkg::ST_NOT_FOUND;
      else a.val = sample_at(it.ch, 0);
      return a;
    end
    ts = it.now - it.dly;
    tl = stamp_at(stamp_cnt - 1);
    if (ts > tl) begin
      // past the newest stamp: lean toward the live value
      if (cc == 0) begin
        a.st = vdl_pkg::ST_NOT_FOUND;
        return a;
      end
      t0 = tl;
      v0 = sample_at(it.ch, cc - 1);
      t1 = it.now;
      v1 = it.xv;
    end else begin
      for (idx = 0; idx < stamp_cnt; idx++)
        if (stamp_at(idx) >= ts) break;
      if (idx >= stamp_cnt || idx >= cc) begin
        a.st = vdl_pkg::ST_NOT_FOUND;
        return a;
      end
      t1 = stamp_at(idx);
      v1 = sample_at(it.ch, idx);
      if (idx == 0) begin
        a.val = v1;
        return a;
      end
      t0 = stamp_at(idx - 1);
      v0 = sample_at(it.ch, idx - 1);
    end
    if (t0 == ts) a.val = v0;
    else if (t1 == ts) a.val = v1;
    else a.val = lerp(v0, v1, t0, t1, ts);
    return a;
  endfunction

  function automatic answer_t apply_item(item_t it);
    answer_t a;
    logic signed [64:0] diff;
    logic signed [63:0] thr;
    int unsigned pos;
    logic ok;
    a.val = '0;
    a.st  = vdl_pkg::ST_OK;
    ok = chan_en_reg[it.ch];
    case (it.op)
      vdl_pkg::OP_STORE_TIME: begin
        diff = $signed({it.now[63], it.now}) - $signed({2'b00, max_dly_reg});
        // saturate at the most negative stamp
        thr  = (diff[64] != diff[63]) ? S_MIN : diff[63:0];
        for (pos = 0; pos < stamp_cnt; pos++)
          if (stamp_at(pos) >= thr) break;
        // keep one stamp older than the threshold
        if (pos >= 2) drop_entries(pos - 1);
        if (stamp_cnt >= DEP) begin
          drop_entries(1);
          a.st = vdl_pkg::ST_OVERFLOW;
        end
        stamp_ring[10'(head_ptr + stamp_cnt)] = it.now;
        stamp_cnt++;
      end
      vdl_pkg::OP_STORE_VALUE: begin
        if (!ok) a.st = vdl_pkg::ST_BAD_CHANNEL;
        else if (sample_cnt[it.ch] >= DEP) a.st = vdl_pkg::ST_OVERFLOW;
        else begin
          sample_ring[it.ch][10'(head_ptr + sample_cnt[it.ch])] = it.xv;
          sample_cnt[it.ch]++;
        end
      end
      vdl_pkg::OP_QUERY: begin
        if (!ok) a.st = vdl_pkg::ST_BAD_CHANNEL;
        else a = lookup(it);
      end
      default: ;
    endcase
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, bookkeeping
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  item_t   pending_items [$];
  answer_t expected_answers [$];
  item_t   held_item;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int orphans = 0;
  int answers_seen = 0;
  int items_sent = 0;

  // Append to the tail of the pending and expected queues.
  function automatic void queue_item(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_answer(answer_t a);
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  // Driver: on acceptance predict the transaction, then offer the next one
  // or go idle. A held item never changes while stalled.
  always @(posedge clk) begin
    item_t   nxt;
    answer_t pr;
    logic    took;
    if (!rst) begin
      took = in_valid && !in_stall;
      if (took) begin
        pr = apply_item(held_item);
        queue_answer(pr);
        items_sent++;
      end
      if (!in_valid || took) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          held_item    = nxt;
          in_valid     <= 1'b1;
          opcode       <= nxt.op;
          channel      <= nxt.ch;
          sample_value <= nxt.xv;
          time_stamp   <= nxt.now;
          delay_amount <= nxt.dly;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        orphans++;
        if (orphans + mismatches <= 10)
          $display("ERROR: result with nothing expected: value=%h status=%0d",
                   delayed_value, status);
      end else begin
        e = expected_answers.pop_front();
        if (delayed_value !== e.val || status !== e.st) begin
          mismatches++;
          if (orphans + mismatches <= 10)
            $display("ERROR: result %0d: expected value=%h status=%0d, got value=%h status=%0d",
                     answers_seen, e.val, e.st, delayed_value, status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic signed [63:0] now_t;

  function automatic item_t mk(logic [1:0] op, logic [2:0] ch, logic signed [63:0] xv,
                               logic signed [63:0] tnow, logic signed [63:0] dly);
    item_t it;
    it.op = op; it.ch = ch; it.xv = xv; it.now = tnow; it.dly = dly;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vdl_pkg::CFG_MAX_DELAY:  max_dly_reg = data[62:0];
      vdl_pkg::CFG_CHAN_EN: begin
        chan_en_reg = data[7:0];
        for (int c = 0; c < NCH; c++)
          if (chan_en_reg[c]) sample_cnt[c] = 0;
      end
      vdl_pkg::CFG_START_TIME: start_reg = data;
      default: ;
    endcase
  endtask

  // Wait until every queued transaction has been sent and answered.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
  endtask

  // One well-formed burst: a new stamp, samples on some channels, queries.
  task automatic push_burst();
    logic signed [63:0] dly;
    now_t += {30'd0, 2'($urandom_range(3)), $urandom};
    queue_item(mk(vdl_pkg::OP_STORE_TIME, 3'($urandom), rnd64(), now_t, rnd64()));
    for (int c = 0; c < NCH; c++)
      if ($urandom_range(3) != 0)
        queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'(c), rnd64(), rnd64(), rnd64()));
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(9))
        0:       dly = -$signed({32'd0, $urandom});
        1:       dly = '0;
        2:       dly = now_t + ONE;
        default: dly = {27'd0, 5'($urandom_range(30)), $urandom};
      endcase
      queue_item(mk(vdl_pkg::OP_QUERY, 3'($urandom), rnd64(),
                    now_t + {31'd0, 1'($urandom), $urandom}, dly));
    end
  endtask

  task automatic random_phase(int n_items, int idle, int stall, logic long_hold);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    while (pending_items.size() < n_items) begin
      if ($urandom_range(9) == 0)
        queue_item(mk(2'($urandom), 3'($urandom), rnd64(), rnd64(), rnd64()));
      else
        push_burst();
    end
    if (long_hold) hold_req++;
    drain();
  endtask

  initial begin
    head_ptr = '0;
    stamp_cnt = 0;
    for (int c = 0; c < NCH; c++) sample_cnt[c] = 0;
    max_dly_reg = '0;
    chan_en_reg = '0;
    start_reg   = '0;
    now_t       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: corner cases on a small, known store
    write_reg(vdl_pkg::CFG_MAX_DELAY, 64'(10 * ONE));
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'h0000_0000_0000_00A5);
    write_reg(vdl_pkg::CFG_START_TIME, 64'd0);
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, S_MAX, ONE, ONE));          // empty: pass
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd1, ONE, 0, 0));          // disabled
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd6, ONE, ONE, 0));              // disabled
    queue_item(mk(2'd3, 3'd7, S_MIN, S_MAX, S_MIN));                   // unused op
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, ONE, ONE, -64'sd1));        // neg delay
    queue_item(mk(vdl_pkg::OP_STORE_TIME, 3'd0, 0, ONE, 0));
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd0, S_MAX, 0, 0));
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd5, 3 * ONE, 0, 0));
    queue_item(mk(vdl_pkg::OP_STORE_TIME, 3'd0, 0, 2 * ONE, 0));
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd0, S_MIN, 0, 0));
    queue_item(mk(vdl_pkg::OP_STORE_TIME, 3'd0, 0, 3 * ONE, 0));
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd0, -ONE, 0, 0));
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 0, 3 * ONE, ONE));          // exact match
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 0, 3 * ONE, ONE / 2 * 3));  // between
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 7 * ONE, 4 * ONE, ONE / 2)); // past newest
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 0, 3 * ONE, 5 * ONE));      // before all
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 9, -ONE, 0));               // before start
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd2, 0, 3 * ONE, ONE));          // no samples
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd5, 0, 3 * ONE, 0));            // too few
    queue_item(mk(vdl_pkg::OP_STORE_TIME, 3'd0, 0, 14 * ONE, 0));      // trim, ch5 empties
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd5, 0, 14 * ONE, 0));
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd0, 0, 14 * ONE, 12 * ONE));
    now_t = 14 * ONE;
    drain();

    // ---- random phases, each under its own register setting
    write_reg(vdl_pkg::CFG_MAX_DELAY, 64'(20 * ONE));
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'hFF);
    random_phase(200, 0, 0, 1'b1);
    write_reg(vdl_pkg::CFG_MAX_DELAY, 64'd0);
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'h0F);
    write_reg(vdl_pkg::CFG_START_TIME, S_MIN);
    random_phase(180, 56, 0, 1'b0);
    write_reg(vdl_pkg::CFG_MAX_DELAY, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'hF3);
    write_reg(vdl_pkg::CFG_START_TIME, now_t + 8 * ONE);
    random_phase(180, 0, 56, 1'b0);
    write_reg(vdl_pkg::CFG_MAX_DELAY, 64'(5 * ONE));
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'h3C);
    write_reg(vdl_pkg::CFG_START_TIME, S_MAX);
    random_phase(60, 19, 19, 1'b0);
    write_reg(vdl_pkg::CFG_START_TIME, 64'd0);
    random_phase(140, 19, 19, 1'b0);

    // ---- disable every channel and poke one
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(vdl_pkg::CFG_CHAN_EN, 64'h00);
    queue_item(mk(vdl_pkg::OP_QUERY, 3'd1, 0, now_t, 0));
    queue_item(mk(vdl_pkg::OP_STORE_VALUE, 3'd1, 0, 0, 0));
    drain();

    repeat (200) @(posedge clk);
    $display("Covered %0d transactions and %0d results over directed cases, five random",
             items_sent, answers_seen);
    $display("phases with idle and stall mixes, a long output hold, and disabled channels.");
    if (mismatches == 0 && orphans == 0 && expected_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
